FILE: rtl/core/sft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sft_pkg
// Shared types and constants for the symbol frequency table.
// ----------------------------------------------------------------------------
package sft_pkg;

  localparam int unsigned TABLE_DEPTH_DEF  = 1024;
  localparam int unsigned MAX_SYMBOL_WIDTH = 20;
  localparam int unsigned MIN_SYMBOL_WIDTH = 8;
  localparam int unsigned COUNT_W          = 32;
  localparam int unsigned BUF_W            = 28;
  localparam int unsigned CFG_W            = 5;

  // commands
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_SORT  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // register indexes
  localparam logic REG_SYMBOL_WIDTH = 1'b0;
  localparam logic REG_LEAD_PAD     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_RD,
    ST_SO_NEXT,
    ST_SO_LD,
    ST_SO_CHK,
    ST_SO_CMP,
    ST_FIN
  } fsm_t;

  function automatic logic [4:0] eff_width(input logic [4:0] w);
    logic [4:0] r;
    r = w;
    if (w < 5'(MIN_SYMBOL_WIDTH)) r = 5'(MIN_SYMBOL_WIDTH);
    if (w > 5'(MAX_SYMBOL_WIDTH)) r = 5'(MAX_SYMBOL_WIDTH);
    return r;
  endfunction

  function automatic logic [4:0] eff_pad(input logic [4:0] w, input logic [4:0] pad);
    logic [4:0] ew;
    ew = eff_width(w);
    return (pad >= ew) ? ew - 5'd1 : pad;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/symbol_frequency_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// symbol_frequency_table
// Bit-stream symbol histogram held in one table memory, with stable sort.
// ----------------------------------------------------------------------------
// Bytes are packed MSB first into a bit buffer; every symbol_width bits form a
// symbol that is looked up in a table of distinct symbols (order of first
// appearance) kept in a single-port-write, registered-read memory. One request
// is worked at a time. A push that completes a symbol scans the table one
// entry per cycle through the memory read port. A sort is an insertion sort
// run through the same memory port. The next request is taken while a
// finished result waits in the output register.
// No clearing pass after reset: entries are only read below the fill count.
module symbol_frequency_table #(
  parameter int unsigned TABLE_DEPTH = sft_pkg::TABLE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [4:0]  cfg_data,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,   // data_byte[7:0], rank_index[17:8], zero fill
  input  wire  [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [71:0] m_tdata,   // status[1:0], symbol_value[21:2],
                                 // symbol_count[53:22], distinct_entries[64:54]
  output logic        m_tuser    // symbol_done
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned EW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW = sft_pkg::MAX_SYMBOL_WIDTH;
  localparam int unsigned CW = sft_pkg::COUNT_W;
  localparam int unsigned BW = sft_pkg::BUF_W;
  localparam int unsigned MW = SW + CW;

  // table memory: {symbol, count}
  logic [MW-1:0] mem [TABLE_DEPTH];
  logic [MW-1:0] mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  sft_pkg::fsm_t state, state_next;

  logic [4:0]    symbol_width;
  logic [4:0]    lead_pad_bits;
  logic [BW-1:0] bit_buffer;
  logic [4:0]    bit_count;
  logic [EW-1:0] entry_count;

  logic [EW-1:0] ra;      // scan read pointer
  logic [EW-1:0] pa;      // address of data in mem_q
  logic          pv;      // mem_q holds a scanned entry
  logic [SW-1:0] sym;     // symbol being looked up
  logic [EW-1:0] si;      // sort outer index
  logic [EW-1:0] sj;      // sort insert position
  logic [SW-1:0] s_sym;
  logic [CW-1:0] s_cnt;

  logic [1:0]    res_status;
  logic          res_done;
  logic [SW-1:0] res_value;
  logic [CW-1:0] res_count;

  // request fields
  logic [1:0] in_cmd;
  logic [7:0] in_byte;
  logic [9:0] in_rank;
  assign in_cmd  = s_tuser;
  assign in_byte = s_tdata[7:0];
  assign in_rank = s_tdata[17:8];

  logic accept;
  assign s_tready = (state == sft_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // push datapath
  logic [4:0]    w_eff;
  logic [BW-1:0] nb;
  logic [4:0]    nc;
  logic          sym_ready;
  logic [4:0]    rem;
  logic [SW-1:0] new_sym;
  logic [BW-1:0] mask_w;
  logic [BW-1:0] mask_rem;

  always_comb begin
    w_eff     = sft_pkg::eff_width(symbol_width);
    nb        = {bit_buffer[BW-9:0], in_byte};
    nc        = bit_count + 5'd8;
    sym_ready = (nc >= w_eff);
    rem       = nc - w_eff;
    mask_w    = ~({BW{1'b1}} << w_eff);
    mask_rem  = ~({BW{1'b1}} << rem);
    new_sym   = SW'((nb >> rem) & mask_w);
  end

  logic rank_ok;
  assign rank_ok = (32'(in_rank) < 32'(entry_count));

  // scan / sort conditions
  logic [SW-1:0] q_sym;
  logic [CW-1:0] q_cnt;
  logic          hit;
  logic          more;
  logic          full;
  logic [CW-1:0] hit_cnt;
  assign q_sym   = mem_q[MW-1:CW];
  assign q_cnt   = mem_q[CW-1:0];
  assign hit     = pv && (q_sym == sym);
  assign more    = (ra < entry_count);
  assign full    = (32'(entry_count) == 32'(TABLE_DEPTH));
  assign hit_cnt = (q_cnt == {CW{1'b1}}) ? q_cnt : q_cnt + CW'(1);

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sft_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            sft_pkg::CMD_PUSH:  state_next = sym_ready ? sft_pkg::ST_SRCH : sft_pkg::ST_FIN;
            sft_pkg::CMD_SORT:  state_next = sft_pkg::ST_SO_NEXT;
            sft_pkg::CMD_READ:  state_next = rank_ok ? sft_pkg::ST_RD : sft_pkg::ST_FIN;
            default:            state_next = sft_pkg::ST_FIN;
          endcase
        end
      end
      sft_pkg::ST_SRCH: begin
        if (hit || !more) state_next = sft_pkg::ST_FIN;
      end
      sft_pkg::ST_RD:      state_next = sft_pkg::ST_FIN;
      sft_pkg::ST_SO_NEXT: state_next = (si < entry_count) ? sft_pkg::ST_SO_LD
                                                            : sft_pkg::ST_FIN;
      sft_pkg::ST_SO_LD:   state_next = sft_pkg::ST_SO_CHK;
      sft_pkg::ST_SO_CHK:  state_next = (sj != '0) ? sft_pkg::ST_SO_CMP
                                                    : sft_pkg::ST_SO_NEXT;
      sft_pkg::ST_SO_CMP:  state_next = (q_cnt < s_cnt) ? sft_pkg::ST_SO_CHK
                                                         : sft_pkg::ST_SO_NEXT;
      sft_pkg::ST_FIN: begin
        if (out_free) state_next = sft_pkg::ST_IDLE;
      end
      default: state_next = sft_pkg::ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pa[AW-1:0];
    mem_wdata = {sym, hit_cnt};
    mem_raddr = ra[AW-1:0];
    unique case (state)
      sft_pkg::ST_IDLE: begin
        mem_raddr = AW'(in_rank);
      end
      sft_pkg::ST_SRCH: begin
        if (hit) begin
          mem_we = 1'b1;
        end else if (!more && !full) begin
          mem_we    = 1'b1;
          mem_waddr = entry_count[AW-1:0];
          mem_wdata = {sym, CW'(1)};
        end
      end
      sft_pkg::ST_SO_NEXT: begin
        mem_raddr = si[AW-1:0];
      end
      sft_pkg::ST_SO_CHK: begin
        mem_raddr = AW'(sj - EW'(1));
        if (sj == '0) begin
          mem_we    = 1'b1;
          mem_waddr = sj[AW-1:0];
          mem_wdata = {s_sym, s_cnt};
        end
      end
      sft_pkg::ST_SO_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = sj[AW-1:0];
        mem_wdata = (q_cnt < s_cnt) ? mem_q : {s_sym, s_cnt};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sft_pkg::ST_IDLE;
      symbol_width  <= 5'(sft_pkg::MIN_SYMBOL_WIDTH);
      lead_pad_bits <= '0;
      bit_buffer    <= '0;
      bit_count     <= '0;
      entry_count   <= '0;
      m_tvalid      <= 1'b0;
      pv            <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready && state != sft_pkg::ST_FIN) m_tvalid <= 1'b0;

      if (cfg_we) begin
        bit_buffer <= '0;
        if (cfg_index == sft_pkg::REG_SYMBOL_WIDTH) begin
          symbol_width <= cfg_data;
          bit_count    <= sft_pkg::eff_pad(cfg_data, lead_pad_bits);
        end else begin
          lead_pad_bits <= cfg_data;
          bit_count     <= sft_pkg::eff_pad(symbol_width, cfg_data);
        end
      end

      unique case (state)
        sft_pkg::ST_IDLE: begin
          if (accept) begin
            res_status <= sft_pkg::ST_OK;
            res_done   <= 1'b0;
            res_value  <= '0;
            res_count  <= '0;
            ra         <= '0;
            pv         <= 1'b0;
            si         <= EW'(1);
            case (in_cmd)
              sft_pkg::CMD_PUSH: begin
                if (sym_ready) begin
                  bit_buffer <= nb & mask_rem;
                  bit_count  <= rem;
                  sym        <= new_sym;
                  res_done   <= 1'b1;
                  res_value  <= new_sym;
                end else begin
                  bit_buffer <= nb;
                  bit_count  <= nc;
                end
              end
              sft_pkg::CMD_READ: begin
                if (!rank_ok) res_status <= sft_pkg::ST_RANGE;
              end
              sft_pkg::CMD_CLEAR: begin
                entry_count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        sft_pkg::ST_SRCH: begin
          if (hit) begin
            res_count <= hit_cnt;
          end else if (more) begin
            pa <= ra;
            ra <= ra + EW'(1);
            pv <= 1'b1;
          end else if (full) begin
            res_status <= sft_pkg::ST_FULL;
          end else begin
            entry_count <= entry_count + EW'(1);
            res_count   <= CW'(1);
          end
        end
        sft_pkg::ST_RD: begin
          res_value <= q_sym;
          res_count <= q_cnt;
        end
        sft_pkg::ST_SO_LD: begin
          s_sym <= q_sym;
          s_cnt <= q_cnt;
          sj    <= si;
        end
        sft_pkg::ST_SO_CHK: begin
          if (sj == '0) si <= si + EW'(1);
        end
        sft_pkg::ST_SO_CMP: begin
          if (q_cnt < s_cnt) sj <= sj - EW'(1);
          else si <= si + EW'(1);
        end
        sft_pkg::ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (state == sft_pkg::ST_FIN && out_free) begin
      m_tdata <= {7'd0, 11'(entry_count), res_count, res_value, res_status};
      m_tuser <= res_done;
    end
  end

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_frequency_table testbench
// Drives push, sort, read and clear requests with random gaps and output
// stalls. A scoreboard keeps its own copy of the bit stream and the symbol
// table, predicts every response and checks it field by field.
// ----------------------------------------------------------------------------

typedef struct {
  logic [1:0]  status;
  logic        done;
  logic [19:0] value;
  logic [31:0] count;
  logic [10:0] entries;
} freq_result_t;

class freq_scoreboard;
  logic [19:0]  sym_mem [sft_pkg::TABLE_DEPTH_DEF];
  logic [31:0]  cnt_mem [sft_pkg::TABLE_DEPTH_DEF];
  int unsigned  n_entries;
  logic [4:0]   width_reg, pad_reg;
  logic [31:0]  bit_buf;
  int unsigned  nbits;
  freq_result_t pending_q[$];
  int           errors;
  int           n_push, n_syms, n_full, n_read, n_sort, n_clear;

  function new();
    width_reg = 5'd8;
    pad_reg   = 5'd0;
    n_entries = 0;
    errors    = 0;
    restart();
  endfunction

  function int unsigned eff_w();
    if (width_reg < sft_pkg::MIN_SYMBOL_WIDTH) return sft_pkg::MIN_SYMBOL_WIDTH;
    if (width_reg > sft_pkg::MAX_SYMBOL_WIDTH) return sft_pkg::MAX_SYMBOL_WIDTH;
    return width_reg;
  endfunction

  function void restart();
    bit_buf = '0;
    nbits   = (pad_reg >= eff_w()) ? eff_w() - 1 : pad_reg;
  endfunction

  function void write_reg(logic idx, logic [4:0] v);
    if (idx == sft_pkg::REG_SYMBOL_WIDTH) width_reg = v;
    else pad_reg = v;
    restart();
  endfunction

  function void note_request(logic [1:0] cmd, logic [7:0] data_b, logic [9:0] rank);
    freq_result_t r;
    int unsigned  w, i, j;
    logic [19:0]  s;
    logic [31:0]  c;
    bit           hit;
    r = '{sft_pkg::ST_OK, 1'b0, 20'd0, 32'd0, 11'd0};
    case (cmd)
      sft_pkg::CMD_PUSH: begin
        n_push++;
        w = eff_w();
        bit_buf = ((bit_buf << 8) | data_b) & ((32'd1 << (nbits + 8)) - 1);
        nbits += 8;
        if (nbits >= w) begin
          n_syms++;
          r.value = 20'((bit_buf >> (nbits - w)) & ((32'd1 << w) - 1));
          nbits -= w;
          bit_buf &= (32'd1 << nbits) - 1;
          r.done = 1'b1;
          hit = 0;
          for (i = 0; i < n_entries; i++) begin
            if (sym_mem[i] == r.value) begin
              hit = 1;
              break;
            end
          end
          if (hit) begin
            if (cnt_mem[i] != 32'hFFFF_FFFF) cnt_mem[i]++;
            r.count = cnt_mem[i];
          end else if (n_entries < sft_pkg::TABLE_DEPTH_DEF) begin
            sym_mem[n_entries] = r.value;
            cnt_mem[n_entries] = 1;
            n_entries++;
            r.count = 1;
          end else begin
            r.status = sft_pkg::ST_FULL;
            n_full++;
          end
        end
      end
      sft_pkg::CMD_SORT: begin
        n_sort++;
        for (i = 1; i < n_entries; i++) begin
          s = sym_mem[i];
          c = cnt_mem[i];
          j = i;
          while (j > 0 && cnt_mem[j-1] < c) begin
            sym_mem[j] = sym_mem[j-1];
            cnt_mem[j] = cnt_mem[j-1];
            j--;
          end
          sym_mem[j] = s;
          cnt_mem[j] = c;
        end
      end
      sft_pkg::CMD_READ: begin
        n_read++;
        if (rank < n_entries) begin
          r.value = sym_mem[rank];
          r.count = cnt_mem[rank];
        end else begin
          r.status = sft_pkg::ST_RANGE;
        end
      end
      default: begin
        n_clear++;
        n_entries = 0;
      end
    endcase
    r.entries = 11'(n_entries);
    pending_q.push_back(r);
  endfunction

  function void check_result(logic [71:0] d, logic u);
    freq_result_t e;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected response tdata=%h tuser=%b", $time, d, u);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (d[1:0] !== e.status) begin
      $display("%0t: status exp %0d got %0d", $time, e.status, d[1:0]);
      errors++;
    end
    if (u !== e.done) begin
      $display("%0t: symbol_done exp %0d got %0d", $time, e.done, u);
      errors++;
    end
    if (d[21:2] !== e.value) begin
      $display("%0t: symbol_value exp %h got %h", $time, e.value, d[21:2]);
      errors++;
    end
    if (d[53:22] !== e.count) begin
      $display("%0t: symbol_count exp %0d got %0d", $time, e.count, d[53:22]);
      errors++;
    end
    if (d[64:54] !== e.entries) begin
      $display("%0t: distinct_entries exp %0d got %0d", $time, e.entries, d[64:54]);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [4:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tuser;

  freq_scoreboard sb = new();
  int  hold_cycles = 0;
  bit  tx_no_gaps  = 0;
  bit  rx_steady   = 0;

  always #6 clk = ~clk;

  symbol_frequency_table i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(15, 60);
    return $urandom_range(1, 3);
  endfunction

  // response side: random stalls, long hold-off on request
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else if (idle > 0) begin
        idle--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) idle = pick_gap();
      end
    end
  end

  task automatic send_req(logic [1:0] cmd, logic [7:0] data_b, logic [9:0] rank);
    int gap;
    gap = tx_no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'd0, rank, data_b};
    do @(posedge clk); while (!s_tready);
    sb.note_request(cmd, data_b, rank);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [4:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_req();
    int unsigned sel;
    logic [7:0]  data_b;
    logic [9:0]  rank;
    sel    = $urandom_range(0, 99);
    data_b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    if ($urandom_range(0, 3) == 0 || sb.n_entries == 0) rank = 10'($urandom);
    else rank = 10'($urandom_range(0, sb.n_entries - 1));
    if (sel < 70)      send_req(sft_pkg::CMD_PUSH, data_b, rank);
    else if (sel < 86) send_req(sft_pkg::CMD_READ, data_b, rank);
    else if (sel < 94) send_req(sft_pkg::CMD_SORT, data_b, rank);
    else               send_req(sft_pkg::CMD_CLEAR, data_b, rank);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, hits, sort order, rank limits
    send_req(sft_pkg::CMD_READ, 8'h00, 10'd0);
    send_req(sft_pkg::CMD_SORT, 8'h00, 10'd0);
    send_req(sft_pkg::CMD_PUSH, 8'h00, 10'd0);
    send_req(sft_pkg::CMD_PUSH, 8'hFF, 10'd0);
    send_req(sft_pkg::CMD_PUSH, 8'hFF, 10'd0);
    send_req(sft_pkg::CMD_READ, 8'h00, 10'd1);
    send_req(sft_pkg::CMD_SORT, 8'h00, 10'd0);
    send_req(sft_pkg::CMD_READ, 8'h00, 10'd0);
    send_req(sft_pkg::CMD_READ, 8'h00, 10'd1023);
    send_req(sft_pkg::CMD_CLEAR, 8'h00, 10'd0);
    send_req(sft_pkg::CMD_PUSH, 8'hA5, 10'd0);
    drain();
    write_cfg(sft_pkg::REG_SYMBOL_WIDTH, 5'd12);
    write_cfg(sft_pkg::REG_LEAD_PAD, 5'd3);
    send_req(sft_pkg::CMD_PUSH, 8'hFF, 10'd0);   // no symbol yet
    send_req(sft_pkg::CMD_PUSH, 8'h5A, 10'd0);
    send_req(sft_pkg::CMD_PUSH, 8'hC3, 10'd0);
    drain();
    write_cfg(sft_pkg::REG_SYMBOL_WIDTH, 5'd0);  // below minimum
    write_cfg(sft_pkg::REG_LEAD_PAD, 5'd31);     // pad saturates
    send_req(sft_pkg::CMD_PUSH, 8'h81, 10'd0);
    send_req(sft_pkg::CMD_PUSH, 8'h7E, 10'd0);
    drain();
    write_cfg(sft_pkg::REG_SYMBOL_WIDTH, 5'd31); // above maximum
    write_cfg(sft_pkg::REG_LEAD_PAD, 5'd19);
    for (int i = 0; i < 5; i++) send_req(sft_pkg::CMD_PUSH, 8'($urandom), 10'd0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(sft_pkg::REG_SYMBOL_WIDTH, 5'($urandom_range(0, 31)));
      write_cfg(sft_pkg::REG_LEAD_PAD, 5'($urandom_range(0, 31)));
      if (ph == 1) begin
        // output held off while requests keep coming
        hold_cycles = 400;
        tx_no_gaps  = 1;
        for (int k = 0; k < 30; k++) random_req();
        tx_no_gaps  = 0;
      end
      if (ph == 4) rx_steady = 1;
      for (int k = 0; k < 66; k++) random_req();
      rx_steady = 0;
      drain();
    end

    repeat (50) @(posedge clk);
    $display("tb: %0d pushes (%0d symbols, %0d dropped), %0d reads, %0d sorts, %0d clears",
             sb.n_push, sb.n_syms, sb.n_full, sb.n_read, sb.n_sort, sb.n_clear);
    $display("tb: widths and pads swept incl. out-of-range values; %0d mismatches",
             sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
